// ===== hw/rtl/lbcp_pkg.sv =====
// Package for the label box collision placer.
// Holds the box type, the sequencer state codes and the result status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbcp_pkg;

  typedef logic signed [15:0] edge_t;

  typedef struct packed {
    edge_t bottom;
    edge_t top;
    edge_t right;
    edge_t left;
  } box_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_BOX    = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_PLACED  = 2'd0;
  localparam status_t STATUS_OVERLAP = 2'd1;
  localparam status_t STATUS_FULL    = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/lbcp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the stored box table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lbcp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/label_box_collision_placer_core.sv =====
// Flow: a taken request is turned into its box, the stored boxes are scanned, and the result is
// registered once the output is free; one stored box is read and compared per cycle in the scan,
// and an overlap ends the scan early.
// A new request is taken only after the result of the last one is issued, bound by the single
// read port of the box table and the one shared box comparator.
// Reset (rst_n, synchronous, active low) clears the sequencer, the box count and the output
// valid; the table contents stay undefined and need no clearing pass.
// Top level of the label box collision placer; uses lbcp_pkg and lbcp_ram.
`timescale 1ns / 1ps
`default_nettype none

module label_box_collision_placer_core #(
  parameter int MAX_LABELS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // center_x[19:0], center_y[39:20], label_width[51:40], label_height[63:52]
  input  wire logic [63:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[1:0], slot[9:2], stored_total[18:10], box_left[34:19], box_right[50:35],
  // box_top[66:51], box_bottom[82:67], zero[87:83]
  output logic      [87:0] out_tdata
);

  import lbcp_pkg::*;

  localparam int AW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int CW = $clog2(MAX_LABELS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_LABELS);

  state_t           state_r, state_nxt;
  logic [19:0]      cx_r, cy_r;
  logic [11:0]      w_r, h_r;
  box_t             box_r, box_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic             overlap_r, overlap_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [87:0]      out_data_r, out_data_nxt;

  logic [63:0]      ram_rdata;
  box_t             rd_box;
  logic             touch;
  logic             hit_now;
  logic             issue;
  logic             out_free;
  logic             ram_we;
  logic             placed;
  status_t          status;
  logic [CW+7:0]    slot_w;
  logic [CW+8:0]    total_w;
  logic [7:0]       slot;
  logic signed [17:0] fx_e, fy_e, hw_e, hh_e;
  box_t             box_calc;

  function automatic edge_t sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  lbcp_ram #(
    .WIDTH (64),
    .DEPTH (MAX_LABELS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (box_r),
    .re    (issue),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    fx_e = {{2{cx_r[19]}}, cx_r[19:4]};
    fy_e = {{2{cy_r[19]}}, cy_r[19:4]};
    hw_e = {7'b0, w_r[11:1]};
    hh_e = {7'b0, h_r[11:1]};
    box_calc.left   = sat16(fx_e - hw_e);
    box_calc.right  = sat16(fx_e + hw_e);
    box_calc.top    = sat16(fy_e - hh_e);
    box_calc.bottom = sat16(fy_e + hh_e);
  end

  assign rd_box   = box_t'(ram_rdata);
  assign touch    = !(rd_box.left > box_r.right || rd_box.right < box_r.left ||
                      rd_box.top > box_r.bottom || rd_box.bottom < box_r.top);
  assign hit_now  = cmp_vld_r && touch;
  assign issue    = (state_r == ST_SCAN) && (idx_r != count_r) && !hit_now;
  assign out_free = !out_valid_r || out_tready;
  assign placed   = !overlap_r && (count_r != COUNT_MAX);
  assign ram_we   = (state_r == ST_DECIDE) && out_free && placed;

  assign status  = overlap_r ? STATUS_OVERLAP : (placed ? STATUS_PLACED : STATUS_FULL);
  assign slot_w  = {8'b0, count_r};
  assign slot    = placed ? slot_w[7:0] : 8'd0;
  assign total_w = {9'b0, count_nxt};

  always_comb begin
    state_nxt     = state_r;
    box_nxt       = box_r;
    idx_nxt       = issue ? idx_r + 1'b1 : idx_r;
    cmp_vld_nxt   = issue;
    overlap_nxt   = overlap_r;
    count_nxt     = count_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_BOX;
        end
      end
      ST_BOX: begin
        box_nxt     = box_calc;
        idx_nxt     = '0;
        overlap_nxt = 1'b0;
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit_now) begin
          overlap_nxt = 1'b1;
          state_nxt   = ST_DECIDE;
        end else if (idx_r == count_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (placed) begin
          count_nxt = count_r + 1'b1;
        end
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, box_r.bottom, box_r.top, box_r.right, box_r.left,
                           total_w[8:0], slot, status};
          state_nxt     = ST_IDLE;
        end else begin
          count_nxt = count_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cx_r <= in_tdata[19:0];
      cy_r <= in_tdata[39:20];
      w_r  <= in_tdata[51:40];
      h_r  <= in_tdata[63:52];
    end
    box_r      <= box_nxt;
    idx_r      <= idx_nxt;
    overlap_r  <= overlap_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lbcp_checker.sv =====
// Port-level assertions for the label box collision placer core.
// Uses lbcp_pkg; bound to label_box_collision_placer_core at the end of this file.
`timescale 1ns / 1ps
`default_nettype none

module lbcp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata
);

  import lbcp_pkg::*;

  status_t            status;
  logic [7:0]         slot;
  logic [8:0]         total;
  logic [8:0]         total_m1;
  logic signed [15:0] left, right, top, bottom;

  assign status   = out_tdata[1:0];
  assign slot     = out_tdata[9:2];
  assign total    = out_tdata[18:10];
  assign total_m1 = total - 9'd1;
  assign left     = out_tdata[34:19];
  assign right    = out_tdata[50:35];
  assign top      = out_tdata[66:51];
  assign bottom   = out_tdata[82:67];

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again without a busy period");

  // A placed box lands in the last slot of the table count.
  a_slot_placed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == STATUS_PLACED |-> slot == total_m1[7:0])
    else $error("placed slot does not match stored total");

  a_slot_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status != STATUS_PLACED |-> slot == 8'd0)
    else $error("rejected result carries a slot");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> left <= right && top <= bottom)
    else $error("box edges out of order");

endmodule

bind label_box_collision_placer_core lbcp_checker u_lbcp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
